@@ hw/rtl/deq_pkg.sv @@
// shared types and constants for the double-ended byte queue
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int OCC_W_DEF = 7;
	localparam int BYTE_W    = 8;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_REAR
	} state_t;

	// moves applied to the cells of the chain; a rear write loads only the selected cell
	typedef struct packed {
		logic shift_r;
		logic shift_l;
		logic wr_rear;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/deq_req_if.sv @@
// command channel: command code and byte to push
`timescale 1ns / 1ps
`default_nettype none
interface deq_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 cmd;
	logic [deq_pkg::BYTE_W-1:0] push_data;

	modport source (output valid, output cmd, output push_data, input ready);
	modport sink   (input valid, input cmd, input push_data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/deq_rsp_if.sv @@
// result channel: popped byte, status and occupancy
`timescale 1ns / 1ps
`default_nettype none
interface deq_rsp_if #(
	parameter int OCC_W = deq_pkg::OCC_W_DEF
);
	logic                       valid;
	logic                       ready;
	logic [deq_pkg::BYTE_W-1:0] pop_data;
	logic [1:0]                 status;
	logic [OCC_W-1:0]           occupancy;

	modport source (output valid, output pop_data, output status, output occupancy,
		input ready);
	modport sink   (input valid, input pop_data, input status, input occupancy,
		output ready);
endinterface
`default_nettype wire

@@ hw/rtl/double_ended_queue.sv @@
// double-ended byte queue built as a shifting chain of storage cells
//
//   channel | dir | fields                          | transfer
//   req     | in  | cmd, push_data                  | req.valid && req.ready
//   rsp     | out | pop_data, status, occupancy     | rsp.valid && rsp.ready
//
// push front, push rear and pop front are each done in a single move: the chain shifts or one cell loads.
// pop rear waits in S_REAR for the registered or-tree that reads the rear cell; no command is taken meanwhile.
// reset clears state, fill count, wait counter and output valid; cells hold no reset value.
// a result waits in the output register; the next command is taken in the cycle it transfers.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int LVL = $clog2(DEPTH);
	localparam int WW  = $clog2(LVL + 1);

	deq_pkg::state_t    state_q, state_d;
	deq_pkg::cell_ctl_t ctl;
	deq_pkg::status_t   status_q, status_d;

	logic [CW-1:0]              count_q, count_d;
	logic [WW-1:0]              wait_q;
	logic                       out_valid_q;
	logic [deq_pkg::BYTE_W-1:0] pop_q, pop_d;
	logic [CW-1:0]              occ_q;
	logic [deq_pkg::BYTE_W-1:0] cell_data [DEPTH];
	logic [deq_pkg::BYTE_W-1:0] leaf      [DEPTH];
	logic [deq_pkg::BYTE_W-1:0] rear_byte;
	logic [DEPTH-1:0]           wr_sel;

	logic accept, out_free, full, empty, is_push, is_pop;
	logic rear_go, rear_done, in_ready;

	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;
	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign is_push  = !req.cmd[1];
	assign is_pop   = req.cmd[1];

	assign ctl.shift_r = accept && req.cmd == deq_pkg::CMD_PUSH_FRONT && !full;
	assign ctl.wr_rear = accept && req.cmd == deq_pkg::CMD_PUSH_REAR && !full;
	assign ctl.shift_l = accept && req.cmd == deq_pkg::CMD_POP_FRONT && !empty;
	assign rear_go     = accept && req.cmd == deq_pkg::CMD_POP_REAR && !empty;

	// cell chain, front byte in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [deq_pkg::BYTE_W-1:0] left_i;
		logic [deq_pkg::BYTE_W-1:0] right_i;

		if (i == 0) begin : g_first
			assign left_i = req.push_data;
		end else begin : g_mid_l
			assign left_i = cell_data[i - 1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_i = cell_data[i];
		end else begin : g_mid_r
			assign right_i = cell_data[i + 1];
		end

		assign wr_sel[i] = count_q == CW'(i);
		assign leaf[i]   = (count_q == CW'(i + 1)) ? cell_data[i] : '0;

		deq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.wr_sel    (wr_sel[i]),
			.push_data (req.push_data),
			.left      (left_i),
			.right     (right_i),
			.data      (cell_data[i])
		);
	end

	deq_rear_tree #(
		.DEPTH (DEPTH)
	) u_rear_tree (
		.clk  (clk),
		.leaf (leaf),
		.root (rear_byte)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deq_pkg::S_IDLE: begin
				if (rear_go) begin
					state_d = deq_pkg::S_REAR;
				end
			end
			deq_pkg::S_REAR: begin
				if (rear_done) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			default: state_d = deq_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		rear_done = 1'b0;
		unique case (state_q)
			deq_pkg::S_IDLE: in_ready  = out_free;
			deq_pkg::S_REAR: rear_done = wait_q == '0 && out_free;
			default: begin
				in_ready  = 1'b0;
				rear_done = 1'b0;
			end
		endcase
	end

	assign req.ready = in_ready;

	always_comb begin
		count_d = count_q;
		if (ctl.shift_r || ctl.wr_rear) begin
			count_d = count_q + 1'b1;
		end else if (ctl.shift_l || rear_done) begin
			count_d = count_q - 1'b1;
		end
	end

	always_comb begin
		pop_d    = '0;
		status_d = deq_pkg::ST_DONE;
		if (rear_done) begin
			pop_d = rear_byte;
		end else if (is_push && full) begin
			status_d = deq_pkg::ST_FULL;
		end else if (is_pop && empty) begin
			status_d = deq_pkg::ST_EMPTY;
		end else if (ctl.shift_l) begin
			pop_d = cell_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::S_IDLE;
			count_q     <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rear_go) begin
				// the wait counter covers the register levels of the tree between the leaf and the root
				wait_q <= WW'(LVL - 1);
			end else if (wait_q != '0) begin
				wait_q <= wait_q - 1'b1;
			end
			if ((accept && !rear_go) || rear_done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((accept && !rear_go) || rear_done) begin
			pop_q    <= pop_d;
			status_q <= status_d;
			occ_q    <= count_d;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.pop_data  = pop_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.shift_r, ctl.shift_l, ctl.wr_rear, rear_done}))
		else $error("more than one chain move in a cycle");

	a_rear_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rear_go |=> state_q == deq_pkg::S_REAR && count_q == $past(count_q))
		else $error("rear pop did not hold the chain");

	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.occupancy == count_q)
		else $error("reported occupancy differs from fill count");
endmodule
`default_nettype wire

@@ hw/rtl/deq_cell.sv @@
// one storage cell of the queue chain, trading its byte with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module deq_cell (
	input  wire                       clk,
	input  wire deq_pkg::cell_ctl_t   ctl,
	input  wire                       wr_sel,
	input  wire [deq_pkg::BYTE_W-1:0] push_data,
	input  wire [deq_pkg::BYTE_W-1:0] left,
	input  wire [deq_pkg::BYTE_W-1:0] right,
	output logic [deq_pkg::BYTE_W-1:0] data
);
	logic [deq_pkg::BYTE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_r) begin
			data_q <= left;
		end else if (ctl.shift_l) begin
			data_q <= right;
		end else if (ctl.wr_rear && wr_sel) begin
			data_q <= push_data;
		end
	end

	assign data = data_q;
endmodule
`default_nettype wire

@@ hw/rtl/deq_rear_tree.sv @@
// registered or-tree that picks out the rear byte of the chain
`timescale 1ns / 1ps
`default_nettype none
module deq_rear_tree #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire                        clk,
	input  wire [deq_pkg::BYTE_W-1:0]  leaf [DEPTH],
	output logic [deq_pkg::BYTE_W-1:0] root
);
	localparam int LVL = $clog2(DEPTH);
	localparam int P   = 1 << LVL;

	// heap order: node k has children 2k and 2k+1, leaves sit at P..2P-1
	logic [deq_pkg::BYTE_W-1:0] node_q [1:P-1];

	for (genvar k = 1; k < P; k++) begin : g_node
		logic [deq_pkg::BYTE_W-1:0] a;
		logic [deq_pkg::BYTE_W-1:0] b;

		if (2 * k >= P) begin : g_leaf
			if (2 * k - P < DEPTH) begin : g_a
				assign a = leaf[2 * k - P];
			end else begin : g_a0
				assign a = '0;
			end
			if (2 * k + 1 - P < DEPTH) begin : g_b
				assign b = leaf[2 * k + 1 - P];
			end else begin : g_b0
				assign b = '0;
			end
		end else begin : g_inner
			assign a = node_q[2 * k];
			assign b = node_q[2 * k + 1];
		end

		always_ff @(posedge clk) begin
			node_q[k] <= a | b;
		end
	end

	assign root = node_q[1];
endmodule
`default_nettype wire
